>>> src/wsdf_pkg.sv
package wsdf_pkg;

	// Parser phases. The halted phase holds after an error until reset.
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT16,
		PH_EXT64,
		PH_MASK,
		PH_PAYLOAD,
		PH_HALT
	} phase_t;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic ERR_FRAGMENTED = 1'b0;
	localparam logic ERR_TOO_LONG   = 1'b1;

	localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// Counter values on the last byte of each multi-byte header field.
	localparam logic [2:0] CNT_EXT16_LAST = 3'd1;
	localparam logic [2:0] CNT_EXT64_LAST = 3'd7;
	localparam logic [2:0] CNT_MASK_LAST  = 3'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic [7:0]  payload;
		logic        last;
		logic        err;
	} result_t;

endpackage

>>> src/wsdf_ifs.sv
interface wsdf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface wsdf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] max_payload_length;

	modport source (output valid, output max_payload_length, input ready);
	modport sink (input valid, input max_payload_length, output ready);
endinterface

interface wsdf_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [3:0]  frame_opcode;
	logic [31:0] frame_length;
	logic [7:0]  payload_byte;
	logic        last_of_frame;
	logic        error_code;

	modport source (
		output valid, output result_kind, output frame_opcode, output frame_length,
		output payload_byte, output last_of_frame, output error_code, input ready
	);
	modport sink (
		input valid, input result_kind, input frame_opcode, input frame_length,
		input payload_byte, input last_of_frame, input error_code, output ready
	);
endinterface

>>> src/wsdf_parser.sv
module wsdf_parser import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        take,
	input  logic [7:0]  byte_in,
	output logic        emit,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        final_q, final_d;
	logic        masked_q, masked_d;
	logic [31:0] len_q, len_d;
	logic        len_hi_q, len_hi_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] key_q, key_d;
	logic [31:0] remain_q, remain_d;
	logic [1:0]  midx_q, midx_d;
	logic [31:0] max_q;

	logic        len_done;
	logic        hdr_done;
	logic        err_flag;
	logic        err_code;
	logic [7:0]  key_byte;
	logic [31:0] len_shift;
	logic        hi_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			final_q  <= 1'b0;
			masked_q <= 1'b0;
			len_q    <= '0;
			len_hi_q <= 1'b0;
			cnt_q    <= '0;
			key_q    <= '0;
			remain_q <= '0;
			midx_q   <= '0;
			max_q    <= MAX_LEN_RESET;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			final_q  <= final_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			len_hi_q <= len_hi_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			remain_q <= remain_d;
			midx_q   <= midx_d;
			if (cfg_we) begin
				max_q <= cfg_data;
			end
		end
	end

	// Only the low 32 bits of the length are kept; a sticky flag records
	// that a nonzero byte was shifted out of the top.
	assign len_shift = {len_q[23:0], byte_in};
	assign hi_shift  = len_hi_q | (len_q[31:24] != 8'd0);

	always_comb begin
		unique case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		final_d  = final_q;
		masked_d = masked_q;
		len_d    = len_q;
		len_hi_d = len_hi_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		remain_d = remain_q;
		midx_d   = midx_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		err_flag = 1'b0;
		err_code = ERR_FRAGMENTED;
		emit     = 1'b0;
		res      = '{kind: KIND_HEADER, opcode: opcode_q, length: '0,
			payload: '0, last: 1'b0, err: 1'b0};

		if (take) begin
			unique case (phase_q)
				PH_HDR0: begin
					final_d  = byte_in[7];
					opcode_d = byte_in[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					if (!final_q) begin
						err_flag = 1'b1;
						err_code = ERR_FRAGMENTED;
					end else begin
						masked_d = byte_in[7];
						key_d    = '0;
						cnt_d    = '0;
						len_hi_d = 1'b0;
						len_d    = '0;
						if (byte_in[6:0] == LEN7_EXT16) begin
							phase_d = PH_EXT16;
						end else if (byte_in[6:0] == LEN7_EXT64) begin
							phase_d = PH_EXT64;
						end else begin
							len_d    = {25'd0, byte_in[6:0]};
							len_done = 1'b1;
						end
					end
				end
				PH_EXT16, PH_EXT64: begin
					len_d    = len_shift;
					len_hi_d = hi_shift;
					if (cnt_q == ((phase_q == PH_EXT16) ? CNT_EXT16_LAST : CNT_EXT64_LAST)) begin
						len_done = 1'b1;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], byte_in};
					if (cnt_q == CNT_MASK_LAST) begin
						cnt_d    = '0;
						hdr_done = 1'b1;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					remain_d = remain_q - 32'd1;
					midx_d   = midx_q + 2'd1;
					if (remain_d == 32'd0) begin
						phase_d = PH_HDR0;
					end
					emit        = 1'b1;
					res.kind    = KIND_PAYLOAD;
					res.payload = byte_in ^ key_byte;
					res.last    = (remain_d == 32'd0);
				end
				PH_HALT: begin
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// The length is complete: check it, then read the key or finish.
			if (len_done) begin
				cnt_d = '0;
				if (len_hi_d || (len_d > max_q)) begin
					err_flag = 1'b1;
					err_code = ERR_TOO_LONG;
				end else if (masked_d) begin
					phase_d = PH_MASK;
				end else begin
					hdr_done = 1'b1;
				end
			end

			if (hdr_done) begin
				remain_d   = len_d;
				midx_d     = '0;
				phase_d    = (len_d == 32'd0) ? PH_HDR0 : PH_PAYLOAD;
				emit       = 1'b1;
				res.kind   = KIND_HEADER;
				res.length = len_d;
				res.last   = (len_d == 32'd0);
			end

			if (err_flag) begin
				phase_d = PH_HALT;
				emit    = 1'b1;
				res     = '{kind: KIND_ERROR, opcode: opcode_q, length: '0,
					payload: '0, last: 1'b0, err: err_code};
			end
		end
	end

endmodule

>>> src/wsdf_out_reg.sv
module wsdf_out_reg import wsdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    emit,
	input  result_t res,
	output logic    can_take,
	wsdf_res_if.source out
);

	logic    valid_q;
	result_t data_q;

	assign can_take = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && emit) begin
			data_q <= res;
		end
	end

	assign out.valid         = valid_q;
	assign out.result_kind   = data_q.kind;
	assign out.frame_opcode  = data_q.opcode;
	assign out.frame_length  = data_q.length;
	assign out.payload_byte  = data_q.payload;
	assign out.last_of_frame = data_q.last;
	assign out.error_code    = data_q.err;

endmodule

>>> src/websocket_frame_deframer_unit.sv
// WebSocket frame receiver. The rx channel carries the connection stream one
// byte per word. The parser reads the two header bytes, an optional 16-bit or
// 64-bit extended length and an optional 4-byte mask key, and then passes the
// payload through, unmasked. The res channel carries one word per header
// (kind 0, with length and opcode), one per payload byte (kind 1, marked last
// on the final byte) and at most one error word (kind 2).
// Latency: a result word is valid in the cycle after the byte that causes it
// is accepted. Throughput: one byte per clock, limited only by the single
// output register, which refills in the same cycle that it is drained.
// When the receiver stalls, rx.ready drops as soon as a result is held, so no
// word is lost; bytes that produce no result still need that register free.
// The cfg channel is always ready and sets the largest allowed payload length;
// write it only while the block is idle.
// Reset (arst_n low) returns the parser to the first header byte, clears the
// output register and sets the length limit to 65536. After an error every
// byte is accepted and dropped until the next reset.
module websocket_frame_deframer_unit import wsdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	wsdf_cfg_if.sink   cfg,
	wsdf_rx_if.sink    rx,
	wsdf_res_if.source res
);

	logic    can_take;
	logic    take;
	logic    emit;
	result_t result;

	// Configuration writes are taken in any cycle.
	assign cfg.ready = 1'b1;

	// A byte is accepted whenever the output register is free or draining.
	assign rx.ready = can_take;
	assign take     = rx.valid && can_take;

	// Header and payload parsing; all per-byte work is combinational.
	wsdf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.max_payload_length),
		.take     (take),
		.byte_in  (rx.stream_byte),
		.emit     (emit),
		.res      (result)
	);

	// Result register that separates the parser from the receiver.
	wsdf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.res      (result),
		.can_take (can_take),
		.out      (res)
	);

endmodule

>>> bench/wsdf_deframe_checker.sv
// Watches the three channels of the frame receiver, predicts every result word
// from the accepted stream bytes and compares each accepted result with the
// oldest prediction still waiting.
module wsdf_deframe_checker import wsdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	wsdf_cfg_if  cfg,
	wsdf_rx_if   rx,
	wsdf_res_if  res,
	output int   fail_count,
	output int   pending,
	output int   header_count,
	output int   payload_count,
	output int   error_count
);

	phase_t      phase;
	logic [3:0]  opcode_q;
	logic        fin_q;
	logic        masked_q;
	logic [63:0] len_acc;
	logic [2:0]  hdr_cnt;
	logic [31:0] mask_key_q;
	logic [31:0] remaining;
	logic [1:0]  key_sel;
	logic [31:0] len_limit;
	result_t     expected_words[$];

	function automatic bit flag_error(input logic code, output result_t r);
		phase = PH_HALT;
		r = '0;
		r.kind = KIND_ERROR;
		r.opcode = opcode_q;
		r.err = code;
		return 1'b1;
	endfunction

	function automatic bit open_frame(output result_t r);
		remaining = len_acc[31:0];
		key_sel = '0;
		phase = (len_acc[31:0] == '0) ? PH_HDR0 : PH_PAYLOAD;
		r = '0;
		r.kind = KIND_HEADER;
		r.opcode = opcode_q;
		r.length = len_acc[31:0];
		r.last = (len_acc[31:0] == '0);
		return 1'b1;
	endfunction

	// The length check comes before any mask key byte is read.
	function automatic bit length_done(output result_t r);
		hdr_cnt = '0;
		r = '0;
		if (len_acc > {32'd0, len_limit})
			return flag_error(ERR_TOO_LONG, r);
		if (masked_q) begin
			phase = PH_MASK;
			return 1'b0;
		end
		return open_frame(r);
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		logic [7:0] key_byte;
		r = '0;
		case (phase)
			PH_HDR0: begin
				fin_q = b[7];
				opcode_q = b[3:0];
				phase = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				if (!fin_q)
					return flag_error(ERR_FRAGMENTED, r);
				masked_q = b[7];
				mask_key_q = '0;
				hdr_cnt = '0;
				len_acc = '0;
				if (b[6:0] == LEN7_EXT16) begin
					phase = PH_EXT16;
					return 1'b0;
				end
				if (b[6:0] == LEN7_EXT64) begin
					phase = PH_EXT64;
					return 1'b0;
				end
				len_acc = {57'd0, b[6:0]};
				return length_done(r);
			end
			PH_EXT16, PH_EXT64: begin
				len_acc = {len_acc[55:0], b};
				if (hdr_cnt == ((phase == PH_EXT16) ? CNT_EXT16_LAST : CNT_EXT64_LAST))
					return length_done(r);
				hdr_cnt = hdr_cnt + 3'd1;
				return 1'b0;
			end
			PH_MASK: begin
				mask_key_q = {mask_key_q[23:0], b};
				if (hdr_cnt == CNT_MASK_LAST) begin
					hdr_cnt = '0;
					return open_frame(r);
				end
				hdr_cnt = hdr_cnt + 3'd1;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				key_byte = mask_key_q[31 - 8 * key_sel -: 8];
				remaining = remaining - 32'd1;
				key_sel = key_sel + 2'd1;
				r.kind = KIND_PAYLOAD;
				r.opcode = opcode_q;
				r.payload = b ^ key_byte;
				r.last = (remaining == '0);
				if (r.last)
					phase = PH_HDR0;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		result_t predicted;
		if (!arst_n) begin
			phase = PH_HDR0;
			opcode_q = '0;
			fin_q = 1'b0;
			masked_q = 1'b0;
			len_acc = '0;
			hdr_cnt = '0;
			mask_key_q = '0;
			remaining = '0;
			key_sel = '0;
			len_limit = MAX_LEN_RESET;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
			header_count = 0;
			payload_count = 0;
			error_count = 0;
		end else begin
			// Results first: a word caused by a byte of this very edge would be too early.
			if (res.valid && res.ready) begin
				got.kind = res.result_kind;
				got.opcode = res.frame_opcode;
				got.length = res.frame_length;
				got.payload = res.payload_byte;
				got.last = res.last_of_frame;
				got.err = res.error_code;
				case (got.kind)
					KIND_HEADER:  header_count++;
					KIND_PAYLOAD: payload_count++;
					KIND_ERROR:   error_count++;
					default: ;
				endcase
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %p", $time, got);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					compare_field("result_kind", 32'(want.kind), 32'(got.kind));
					compare_field("frame_opcode", 32'(want.opcode), 32'(got.opcode));
					compare_field("frame_length", want.length, got.length);
					compare_field("payload_byte", 32'(want.payload), 32'(got.payload));
					compare_field("last_of_frame", 32'(want.last), 32'(got.last));
					compare_field("error_code", 32'(want.err), 32'(got.err));
				end
			end
			if (rx.valid && rx.ready) begin
				if (deframe_byte(rx.stream_byte, predicted))
					expected_words.insert(expected_words.size(), predicted);
			end
			if (cfg.valid && cfg.ready)
				len_limit = cfg.max_payload_length;
			pending = expected_words.size();
		end
	end

endmodule

>>> bench/tb_websocket_frame_deframer_unit.sv
// Top of the frame receiver bench. This module only makes stimulus and gives
// the verdict; prediction and comparison live in the checker beside the block.
module tb_websocket_frame_deframer_unit;
	import wsdf_pkg::*;

	// How a frame states its payload length on the wire.
	typedef enum int {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	// The one error that ends the run, since only a reset clears the halt.
	typedef enum int {
		TAIL_FRAGMENTED,
		TAIL_SHORT_OVER,
		TAIL_EXT16_OVER,
		TAIL_EXT64_HUGE
	} tail_t;

	localparam int PHASE_COUNT = 6;
	localparam int PHASE_BYTES = 225;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;

	wsdf_cfg_if cfg ();
	wsdf_rx_if  rx ();
	wsdf_res_if res ();

	int fail_count;
	int pending;
	int header_count;
	int payload_count;
	int error_count;

	// Idle percentages are set by the stimulus and read by the sender task and the receiver process.
	int send_idle_pct = 28;
	int recv_idle_pct = 65;
	// A long receiver stall is requested by bumping hold_asked; the receiver
	// process serves each request once and counts the stall down itself.
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	logic [31:0] limit_now;

	websocket_frame_deframer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.res    (res)
	);

	wsdf_deframe_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.rx            (rx),
		.res           (res),
		.fail_count    (fail_count),
		.pending       (pending),
		.header_count  (header_count),
		.payload_count (payload_count),
		.error_count   (error_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side. Ready changes only on the falling edge. During a requested
	// hold-off ready stays low while the sender keeps offering bytes, so the
	// single output register fills and the block has to stall its input.
	initial res.ready = 1'b0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left--;
		end else if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one stream word, with random idle cycles in front of it, and
	// returns at the falling edge after the word was taken. Valid is left high
	// so that back-to-back words need no extra assignment in one time step.
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.stream_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Lets every predicted word come out, then lets the block settle further
	// in case the last byte taken produces nothing.
	task automatic drain_and_settle();
		rx.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The limit register is only written once the block is idle.
	task automatic write_limit(input logic [31:0] value);
		drain_and_settle();
		cfg.valid <= 1'b1;
		cfg.max_payload_length <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		limit_now = value;
	endtask

	// One complete final frame. The reserved bits of the first byte are random
	// since the block ignores them; the mask key and the payload are random.
	task automatic send_frame(input logic [3:0] op, input logic [31:0] len, input bit masked,
			input len_form_t form);
		logic [31:0] key;
		key = $urandom();
		push_byte({1'b1, 3'($urandom_range(7)), op});
		case (form)
			LEN_SHORT: begin
				push_byte({masked, len[6:0]});
			end
			LEN_EXT16: begin
				push_byte({masked, LEN7_EXT16});
				push_byte(len[15:8]);
				push_byte(len[7:0]);
			end
			default: begin
				push_byte({masked, LEN7_EXT64});
				repeat (4) push_byte(8'h00);
				for (int i = 3; i >= 0; i--)
					push_byte(len[8 * i +: 8]);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				push_byte(key[8 * i +: 8]);
		repeat (len) push_byte(8'($urandom()));
	endtask

	// Lengths stay small so that frames are many; now and then a frame is empty,
	// sits exactly on the cap (the limit, if under 40) or is a few hundred bytes long.
	// Short lengths also go out in the longer encodings, which the block must accept.
	task automatic send_random_frame();
		logic [31:0] cap;
		logic [31:0] len;
		len_form_t form;
		cap = (limit_now < 32'd40) ? limit_now : 32'd40;
		if ($urandom_range(15) == 0 && limit_now >= 32'd300)
			cap = 32'd300;
		case ($urandom_range(9))
			0: len = '0;
			1: len = cap;
			default: len = $urandom_range(cap, 0);
		endcase
		if (len < 32'd126)
			form = len_form_t'($urandom_range(2));
		else
			form = ($urandom_range(1) == 0) ? LEN_EXT16 : LEN_EXT64;
		send_frame(4'($urandom_range(15)), len, $urandom_range(3) != 0, form);
	endtask

	initial begin
		logic [31:0] phase_limit [PHASE_COUNT];
		tail_t tail;
		int start_bytes;

		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.stream_byte = '0;
		cfg.valid = 1'b0;
		cfg.max_payload_length = '0;
		limit_now = MAX_LEN_RESET;

		// The first phase runs on the reset value; the others sweep the limit
		// from zero up to the all-ones value and back to small values.
		phase_limit[0] = MAX_LEN_RESET;
		phase_limit[1] = 32'd0;
		phase_limit[2] = 32'hFFFF_FFFF;
		phase_limit[3] = 32'($urandom_range(40, 1));
		phase_limit[4] = 32'd300;
		phase_limit[5] = 32'($urandom_range(100, 20));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames: empty frames with and without a mask key, the
		// lowest and highest opcode, all three length encodings, and a masked
		// payload long enough for the key index to wrap.
		send_frame(4'h0, 32'd0, 1'b0, LEN_SHORT);
		send_frame(4'hF, 32'd0, 1'b1, LEN_EXT64);
		send_frame(4'h1, 32'd3, 1'b0, LEN_SHORT);
		send_frame(4'h2, 32'd2, 1'b1, LEN_EXT16);
		send_frame(4'h9, 32'd5, 1'b1, LEN_SHORT);
		send_frame(4'hA, 32'd1, 1'b0, LEN_EXT64);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p < 2) begin
				send_idle_pct = 28;
				recv_idle_pct = 65;
			end else if (p < 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p > 0)
				write_limit(phase_limit[p]);
			// Long result stall while the sender keeps going.
			if (p == 2)
				hold_asked++;
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < PHASE_BYTES)
				send_random_frame();
		end

		// The run ends with one header error. The limit is small here, so
		// every length form can exceed it; a 64-bit length with its top bit
		// set is always too long. Afterwards the block must drop every byte.
		tail = tail_t'($urandom_range(3));
		case (tail)
			TAIL_FRAGMENTED: begin
				push_byte({1'b0, 3'($urandom_range(7)), 4'($urandom_range(15))});
				push_byte(8'($urandom()));
			end
			TAIL_SHORT_OVER: begin
				push_byte({1'b1, 3'($urandom_range(7)), 4'($urandom_range(15))});
				push_byte({1'($urandom_range(1)), 7'($urandom_range(125, limit_now + 1))});
			end
			TAIL_EXT16_OVER: begin
				push_byte({1'b1, 3'($urandom_range(7)), 4'($urandom_range(15))});
				push_byte({1'($urandom_range(1)), LEN7_EXT16});
				begin : ext16_len
					logic [15:0] big;
					big = 16'($urandom_range(65535, limit_now + 1));
					push_byte(big[15:8]);
					push_byte(big[7:0]);
				end
			end
			default: begin
				push_byte({1'b1, 3'($urandom_range(7)), 4'($urandom_range(15))});
				push_byte({1'($urandom_range(1)), LEN7_EXT64});
				push_byte(8'h80 | 8'($urandom()));
				repeat (7) push_byte(8'($urandom()));
			end
		endcase
		repeat (24) push_byte(8'($urandom()));

		drain_and_settle();

		$display("Sent %0d stream bytes under six length limits, zero and all-ones among them.",
			bytes_sent);
		$display("Checked %0d headers, %0d payload bytes and %0d error word(s), ending on %s.",
			header_count, payload_count, error_count, tail.name());
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#(12 * 600000);
		$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
src/wsdf_pkg.sv
src/wsdf_ifs.sv
src/wsdf_parser.sv
src/wsdf_out_reg.sv
src/websocket_frame_deframer_unit.sv
bench/wsdf_deframe_checker.sv
bench/tb_websocket_frame_deframer_unit.sv
